// ===== rtl/kbl_pkg.sv =====
// Shared types and constants for the largest-person bounding box block.
`timescale 1ns / 1ps

package kbl_pkg;

   // Fixed widths of the beat fields.
   localparam int FIELD_W = 16;
   localparam int INDEX_W = 6;
   localparam int AREA_W  = 32;

   // Score threshold after reset, Q0.16 (about 0.1).
   localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 16'd6554;

   // One keypoint beat on the request channel.
   typedef struct packed {
      logic [FIELD_W-1:0] coord_x;
      logic [FIELD_W-1:0] coord_y;
      logic [FIELD_W-1:0] confidence;
      logic               person_end;
      logic               frame_end;
      logic               empty_frame;
   } req_type;

   // One result beat on the response channel.
   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] best_person;
      logic [AREA_W-1:0]  best_area;
      logic [FIELD_W-1:0] box_left;
      logic [FIELD_W-1:0] box_top;
      logic [FIELD_W-1:0] box_width;
      logic [FIELD_W-1:0] box_height;
      logic               too_many_people;
   } rsp_type;

   // Control flags that travel with a closed person or a frame end down the pipe.
   typedef struct packed {
      logic close;
      logic emit;
      logic found;
      logic overflow;
   } ctl_type;

endpackage

// ===== rtl/keypoint_bbox_largest_person_core.sv =====
// Top level of the largest-person bounding box block.
`timescale 1ns / 1ps
// Usage:
//  Keypoints enter one beat at a time on the req_ channel (valid/ready), person
//  by person, with person_end and frame_end flags; an empty_frame beat closes a
//  frame that has no keypoint. One result beat per frame leaves on the rsp_
//  channel: the index, area and box of the first person of greatest box area.
//  csr_we/csr_wdata write the score threshold; only keypoints with a score
//  strictly above it widen a person's box. Write it only while the block idles.
//  Throughput is one keypoint beat per cycle while req_ready is high. A frame
//  result passes three registers: the min/max update and box forming, the
//  width by height multiplier, and the area compare that loads the result
//  register. rsp_valid rises when that last register is loaded.
//  Reset is synchronous and active high; it clears all frame state and sets
//  the threshold to 6554 (about 0.1). No clearing pass is needed.
//  When the receiver stalls, the result register holds its beat. A further
//  frame end then waits in the multiplier stage, and a person end or frame end
//  behind it waits in the box register. Keypoint beats keep flowing until both
//  have happened; only then does back-pressure reach req_ready.

module keypoint_bbox_largest_person_core #(
   parameter int MAX_PEOPLE = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [kbl_pkg::FIELD_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kbl_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kbl_pkg::rsp_type              rsp_data
);

   // Coordinates beyond the field width carry no bits.
   localparam int CW    = (COORD_BITS < kbl_pkg::FIELD_W) ? COORD_BITS : kbl_pkg::FIELD_W;
   localparam int CNT_W = $clog2(MAX_PEOPLE + 1);

   logic               acc_valid, acc_ready;
   kbl_pkg::ctl_type   acc_ctl;
   logic [CNT_W-1:0]   acc_index;
   logic [CW-1:0]      acc_left, acc_top, acc_width, acc_height;

   logic               area_valid, area_ready;
   kbl_pkg::ctl_type   area_ctl;
   logic [CNT_W-1:0]   area_index;
   logic [2*CW-1:0]    area_area;
   logic [CW-1:0]      area_left, area_top, area_width, area_height;

   // Running extremes and box forming.
   kbl_accum #(
      .CW    (CW),
      .CNT_W (CNT_W),
      .MAX_P (MAX_PEOPLE)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .out_valid  (acc_valid),
      .out_ready  (acc_ready),
      .out_ctl    (acc_ctl),
      .out_index  (acc_index),
      .out_left   (acc_left),
      .out_top    (acc_top),
      .out_width  (acc_width),
      .out_height (acc_height)
   );

   // Box area.
   kbl_area #(
      .CW    (CW),
      .CNT_W (CNT_W)
   ) u_area (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (acc_valid),
      .in_ready   (acc_ready),
      .in_ctl     (acc_ctl),
      .in_index   (acc_index),
      .in_left    (acc_left),
      .in_top     (acc_top),
      .in_width   (acc_width),
      .in_height  (acc_height),
      .out_valid  (area_valid),
      .out_ready  (area_ready),
      .out_ctl    (area_ctl),
      .out_index  (area_index),
      .out_area   (area_area),
      .out_left   (area_left),
      .out_top    (area_top),
      .out_width  (area_width),
      .out_height (area_height)
   );

   // Largest-area selection and result register.
   kbl_select #(
      .CW    (CW),
      .CNT_W (CNT_W)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (area_valid),
      .in_ready   (area_ready),
      .in_ctl     (area_ctl),
      .in_index   (area_index),
      .in_area    (area_area),
      .in_left    (area_left),
      .in_top     (area_top),
      .in_width   (area_width),
      .in_height  (area_height),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/kbl_accum.sv =====
// Keypoint accumulator: running extremes per person, person count and box forming.
`timescale 1ns / 1ps

module kbl_accum #(
   parameter int CW    = 16,
   parameter int CNT_W = 7,
   parameter int MAX_P = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [kbl_pkg::FIELD_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kbl_pkg::req_type              req_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output kbl_pkg::ctl_type              out_ctl,
   output logic [CNT_W-1:0]              out_index,
   output logic [CW-1:0]                 out_left,
   output logic [CW-1:0]                 out_top,
   output logic [CW-1:0]                 out_width,
   output logic [CW-1:0]                 out_height
);

   logic [kbl_pkg::FIELD_W-1:0] threshold_ff;
   logic [CW-1:0]               min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [CW-1:0]               min_x_in, max_x_in, min_y_in, max_y_in;
   logic                        any_ff, any_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic                        valid_ff, valid_in;
   kbl_pkg::ctl_type            ctl_ff, ctl_in;
   logic [CNT_W-1:0]            index_ff;
   logic [CW-1:0]               left_ff, top_ff, width_ff, height_ff;
   logic [CW-1:0]               left_in, top_in, width_in, height_in;

   logic          advance, take, full, hit, close_req, close, emit;
   logic [CW-1:0] x, y;
   logic [CNT_W-1:0] count_next;
   logic          ovf_next;

   // The output register frees up when empty or when its beat is taken.
   assign advance   = !valid_ff || out_ready;
   assign req_ready = advance;
   assign take      = req_valid && advance;

   assign x = req_data.coord_x[CW-1:0];
   assign y = req_data.coord_y[CW-1:0];

   // Keypoint qualification, person close and frame end decode.
   assign full      = (count_ff >= CNT_W'(MAX_P));
   assign hit       = !req_data.empty_frame && !full && (req_data.confidence > threshold_ff);
   assign close_req = !req_data.empty_frame && (req_data.person_end || req_data.frame_end);
   assign close     = close_req && !full;
   assign emit      = req_data.empty_frame || req_data.frame_end;
   assign count_next = count_ff + CNT_W'(close);
   assign ovf_next   = ovf_ff || (close_req && full);

   // Running extremes including the current keypoint.
   always_comb begin
      min_x_in = (hit && (x < min_x_ff)) ? x : min_x_ff;
      max_x_in = (hit && (x > max_x_ff)) ? x : max_x_ff;
      min_y_in = (hit && (y < min_y_ff)) ? y : min_y_ff;
      max_y_in = (hit && (y > max_y_ff)) ? y : max_y_ff;
      any_in   = any_ff || hit;
   end

   // Box of the person being closed; empty when no keypoint counted.
   always_comb begin
      if (any_in) begin
         left_in   = min_x_in;
         top_in    = min_y_in;
         width_in  = max_x_in - min_x_in;
         height_in = max_y_in - min_y_in;
      end else begin
         left_in   = '0;
         top_in    = '0;
         width_in  = '0;
         height_in = '0;
      end
   end

   // Control flags for the next pipeline stage.
   always_comb begin
      ctl_in.close    = close;
      ctl_in.emit     = emit;
      ctl_in.found    = (count_next != '0);
      ctl_in.overflow = ovf_next;
      valid_in        = advance ? (take && (close || emit)) : valid_ff;
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kbl_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         threshold_ff <= csr_wdata;
      end
   end

   // Person and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '1;
         min_y_ff <= '1;
         max_x_ff <= '0;
         max_y_ff <= '0;
         any_ff   <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            if (emit || close_req) begin
               min_x_ff <= '1;
               min_y_ff <= '1;
               max_x_ff <= '0;
               max_y_ff <= '0;
               any_ff   <= 1'b0;
            end else begin
               min_x_ff <= min_x_in;
               min_y_ff <= min_y_in;
               max_x_ff <= max_x_in;
               max_y_ff <= max_y_in;
               any_ff   <= any_in;
            end
            if (emit) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               count_ff <= count_next;
               ovf_ff   <= ovf_next;
            end
         end
      end
   end

   // Payload of the outgoing record.
   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff    <= ctl_in;
         index_ff  <= count_ff;
         left_ff   <= left_in;
         top_ff    <= top_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_index  = index_ff;
   assign out_left   = left_ff;
   assign out_top    = top_ff;
   assign out_width  = width_ff;
   assign out_height = height_ff;

endmodule

// ===== rtl/kbl_area.sv =====
// Area stage: registered product of box width and height.
`timescale 1ns / 1ps

module kbl_area #(
   parameter int CW    = 16,
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  kbl_pkg::ctl_type     in_ctl,
   input  logic [CNT_W-1:0]     in_index,
   input  logic [CW-1:0]        in_left,
   input  logic [CW-1:0]        in_top,
   input  logic [CW-1:0]        in_width,
   input  logic [CW-1:0]        in_height,
   output logic                 out_valid,
   input  logic                 out_ready,
   output kbl_pkg::ctl_type     out_ctl,
   output logic [CNT_W-1:0]     out_index,
   output logic [2*CW-1:0]      out_area,
   output logic [CW-1:0]        out_left,
   output logic [CW-1:0]        out_top,
   output logic [CW-1:0]        out_width,
   output logic [CW-1:0]        out_height
);

   logic                valid_ff;
   logic                take;
   logic [2*CW-1:0]     area_in, area_ff;
   kbl_pkg::ctl_type    ctl_ff;
   logic [CNT_W-1:0]    index_ff;
   logic [CW-1:0]       left_ff, top_ff, width_ff, height_ff;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign area_in  = in_width * in_height;

   // Stage valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Product and the record that travels with it.
   always_ff @(posedge clock) begin
      if (take) begin
         area_ff   <= area_in;
         ctl_ff    <= in_ctl;
         index_ff  <= in_index;
         left_ff   <= in_left;
         top_ff    <= in_top;
         width_ff  <= in_width;
         height_ff <= in_height;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_index  = index_ff;
   assign out_area   = area_ff;
   assign out_left   = left_ff;
   assign out_top    = top_ff;
   assign out_width  = width_ff;
   assign out_height = height_ff;

endmodule

// ===== rtl/kbl_select.sv =====
// Selection stage: keeps the largest box of the frame and holds the result beat.
`timescale 1ns / 1ps

module kbl_select #(
   parameter int CW    = 16,
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  kbl_pkg::ctl_type     in_ctl,
   input  logic [CNT_W-1:0]     in_index,
   input  logic [2*CW-1:0]      in_area,
   input  logic [CW-1:0]        in_left,
   input  logic [CW-1:0]        in_top,
   input  logic [CW-1:0]        in_width,
   input  logic [CW-1:0]        in_height,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kbl_pkg::rsp_type     rsp_data
);

   logic                have_ff, have_in;
   logic [2*CW-1:0]     area_ff, area_in;
   logic [CNT_W-1:0]    index_ff, index_in;
   logic [CW-1:0]       left_ff, top_ff, width_ff, height_ff;
   logic [CW-1:0]       left_in, top_in, width_in, height_in;
   logic                rsp_valid_ff;
   kbl_pkg::rsp_type    rsp_ff, rsp_in;

   logic                take, better;
   logic [CNT_W+kbl_pkg::INDEX_W-1:0] index_ext;

   // Only a frame-end beat needs room in the result register.
   assign in_ready = !in_ctl.emit || !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   // First person of strictly greatest area wins.
   assign better = in_ctl.close && (!have_ff || (in_area > area_ff));

   always_comb begin
      if (better) begin
         have_in   = 1'b1;
         area_in   = in_area;
         index_in  = in_index;
         left_in   = in_left;
         top_in    = in_top;
         width_in  = in_width;
         height_in = in_height;
      end else begin
         have_in   = have_ff;
         area_in   = area_ff;
         index_in  = index_ff;
         left_in   = left_ff;
         top_in    = top_ff;
         width_in  = width_ff;
         height_in = height_ff;
      end
   end

   // Result beat; every field reads zero when no person was closed.
   assign index_ext = {{kbl_pkg::INDEX_W{1'b0}}, index_in};

   always_comb begin
      rsp_in = '0;
      if (in_ctl.found) begin
         rsp_in.found           = 1'b1;
         rsp_in.best_person     = index_ext[kbl_pkg::INDEX_W-1:0];
         rsp_in.best_area       = kbl_pkg::AREA_W'(area_in);
         rsp_in.box_left        = kbl_pkg::FIELD_W'(left_in);
         rsp_in.box_top         = kbl_pkg::FIELD_W'(top_in);
         rsp_in.box_width       = kbl_pkg::FIELD_W'(width_in);
         rsp_in.box_height      = kbl_pkg::FIELD_W'(height_in);
         rsp_in.too_many_people = in_ctl.overflow;
      end
   end

   // Kept best and result handshake; a frame end clears the kept best.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         area_ff      <= '0;
         index_ff     <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take && in_ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            if (in_ctl.emit) begin
               have_ff   <= 1'b0;
               area_ff   <= '0;
               index_ff  <= '0;
               left_ff   <= '0;
               top_ff    <= '0;
               width_ff  <= '0;
               height_ff <= '0;
            end else begin
               have_ff   <= have_in;
               area_ff   <= area_in;
               index_ff  <= index_in;
               left_ff   <= left_in;
               top_ff    <= top_in;
               width_ff  <= width_in;
               height_ff <= height_in;
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (take && in_ctl.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
